/* src/msts_pkg.sv */
// Shared types and constants of the multi-slot timer scheduler.
// Used by msts_ctrl, msts_dp and the top module; depends on nothing.
package msts_pkg;

   localparam int SLOTS = 16;
   localparam int TIME_BITS = 32;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_FIRES = 16;
   localparam int CNT_BITS = $clog2(MAX_FIRES + 1);
   localparam int DELAY_BITS = 16;
   localparam int PERIOD_BITS = 16;
   localparam int HANDLE_BITS = 4;
   localparam int SLOT_OUT_BITS = 4;

   typedef enum logic [1:0] {
      MODE_SCHED  = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_SCHED  = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_FIRE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_FIRE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [DELAY_BITS-1:0]  start_delay;
      logic [PERIOD_BITS-1:0] period_ms;
      logic [HANDLE_BITS-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [SLOT_OUT_BITS-1:0] slot;
      logic                     ok;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic scan_clear;
      logic scan_step;
      logic fire;
      logic emit_pend;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic best_valid;
      logic pend_valid;
      logic cap_hit;
      logic out_free;
   } status_type;

endpackage

/* src/msts_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module msts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/msts_ctrl.sv */
// Controller state machine of the timer scheduler.
// Depends on msts_pkg; drives the datapath through cmd_type, reads status_type.
module msts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   input  msts_pkg::status_type status,
   output logic                 req_stall,
   output msts_pkg::cmd_type    cmd
);
   import msts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = !((state_ff == ST_IDLE) && status.out_free);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.accept = 1'b1;
               if (req_mode == MODE_TICK) begin
                  cmd.scan_clear = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_FIRE;
         end
         ST_FIRE: begin
            if (status.best_valid) begin
               if (!status.pend_valid || status.out_free) begin
                  cmd.fire = 1'b1;
                  cmd.emit_pend = status.pend_valid;
                  if (status.cap_hit) begin
                     state_in = ST_FLUSH;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in = ST_SCAN;
                  end
               end
            end else if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_pend = 1'b1;
               cmd.emit_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit_pend = 1'b1;
               cmd.emit_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/msts_dp.sv */
// Datapath of the timer scheduler: clock, slot table, scan and result register.
// Depends on msts_pkg and msts_ram; controlled by msts_ctrl.
module msts_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  msts_pkg::cmd_type    cmd,
   input  msts_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output msts_pkg::status_type status,
   output logic                 rsp_valid,
   output msts_pkg::rsp_type    rsp_data
);
   import msts_pkg::*;

   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SLOTS-1:0]       active_ff, active_in;
   logic [SLOT_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic                   cmp_valid_ff;
   logic [SLOT_BITS-1:0]   cmp_idx_ff;
   logic                   best_valid_ff, best_valid_in;
   logic [SLOT_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]   best_late_ff, best_late_in;
   logic [PERIOD_BITS-1:0] best_period_ff, best_period_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [SLOT_BITS-1:0]   pend_slot_ff, pend_slot_in;
   logic [CNT_BITS-1:0]    fire_cnt_ff, fire_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   due_wr_en;
   logic [SLOT_BITS-1:0]   due_wr_addr;
   logic [TIME_BITS-1:0]   due_wr_data;
   logic [TIME_BITS-1:0]   due_rd_data;
   logic [PERIOD_BITS-1:0] per_rd_data;

   logic                   do_sched, do_cancel, do_tick, sched_wr;
   logic                   free_found;
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   cancel_ok;
   logic [TIME_BITS-1:0]   late;
   logic                   cmp_hit;
   logic                   out_free;
   logic                   rsp_load;

   assign do_sched  = cmd.accept && (req_data.mode == MODE_SCHED);
   assign do_cancel = cmd.accept && (req_data.mode == MODE_CANCEL);
   assign do_tick   = cmd.accept && (req_data.mode == MODE_TICK);
   assign sched_wr  = do_sched && free_found;

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   assign cancel_ok = (32'(req_data.handle) < SLOTS)
                      && active_ff[SLOT_BITS'(req_data.handle)];

   msts_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_due_ram (
      .clock   (clock),
      .wr_en   (due_wr_en),
      .wr_addr (due_wr_addr),
      .wr_data (due_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (due_rd_data)
   );

   msts_ram #(.WIDTH(PERIOD_BITS), .DEPTH(SLOTS)) u_per_ram (
      .clock   (clock),
      .wr_en   (sched_wr),
      .wr_addr (free_idx),
      .wr_data (req_data.period_ms),
      .rd_addr (scan_idx_ff),
      .rd_data (per_rd_data)
   );

   always_comb begin
      due_wr_en = 1'b0;
      due_wr_addr = free_idx;
      due_wr_data = now_ff + TIME_BITS'(req_data.start_delay);
      if (sched_wr) begin
         due_wr_en = 1'b1;
      end else if (cmd.fire && (best_period_ff != '0)) begin
         due_wr_en = 1'b1;
         due_wr_addr = best_idx_ff;
         due_wr_data = now_ff + TIME_BITS'(best_period_ff);
      end
   end

   assign late = now_ff - due_rd_data;
   assign cmp_hit = cmp_valid_ff && active_ff[cmp_idx_ff] && !late[TIME_BITS-1]
                    && (!best_valid_ff || (late > best_late_ff));

   always_comb begin
      now_in = do_tick ? now_ff + TIME_BITS'(1) : now_ff;

      active_in = active_ff;
      if (sched_wr) begin
         active_in[free_idx] = 1'b1;
      end
      if (do_cancel && cancel_ok) begin
         active_in[SLOT_BITS'(req_data.handle)] = 1'b0;
      end
      if (cmd.fire && (best_period_ff == '0)) begin
         active_in[best_idx_ff] = 1'b0;
      end

      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clear) begin
         scan_idx_in = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
      end

      best_valid_in = best_valid_ff;
      best_idx_in = best_idx_ff;
      best_late_in = best_late_ff;
      best_period_in = best_period_ff;
      if (cmd.scan_clear) begin
         best_valid_in = 1'b0;
      end else if (cmp_hit) begin
         best_valid_in = 1'b1;
         best_idx_in = cmp_idx_ff;
         best_late_in = late;
         best_period_in = per_rd_data;
      end

      pend_valid_in = pend_valid_ff;
      pend_slot_in = pend_slot_ff;
      if (do_tick) begin
         pend_valid_in = 1'b0;
      end else if (cmd.fire) begin
         pend_valid_in = 1'b1;
         pend_slot_in = best_idx_ff;
      end else if (cmd.emit_pend) begin
         pend_valid_in = 1'b0;
      end

      fire_cnt_in = fire_cnt_ff;
      if (do_tick) begin
         fire_cnt_in = '0;
      end else if (cmd.fire) begin
         fire_cnt_in = fire_cnt_ff + CNT_BITS'(1);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_load = 1'b0;
      rsp_in = rsp_ff;
      if (do_sched) begin
         rsp_load = 1'b1;
         if (free_found) begin
            rsp_in.kind = KIND_SCHED;
            rsp_in.slot = SLOT_OUT_BITS'(free_idx);
            rsp_in.ok = 1'b1;
         end else begin
            rsp_in.kind = KIND_FULL;
            rsp_in.slot = '0;
            rsp_in.ok = 1'b0;
         end
         rsp_in.last = 1'b1;
      end else if (do_cancel) begin
         rsp_load = 1'b1;
         rsp_in.kind = KIND_CANCEL;
         rsp_in.slot = req_data.handle;
         rsp_in.ok = cancel_ok;
         rsp_in.last = 1'b1;
      end else if (cmd.emit_pend) begin
         rsp_load = 1'b1;
         rsp_in.kind = KIND_FIRE;
         rsp_in.slot = SLOT_OUT_BITS'(pend_slot_ff);
         rsp_in.ok = 1'b1;
         rsp_in.last = cmd.emit_last;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         active_ff <= '0;
         cmp_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff <= now_in;
         active_ff <= active_in;
         cmp_valid_ff <= cmd.scan_step;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff <= fire_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff <= scan_idx_ff;
      best_idx_ff <= best_idx_in;
      best_late_ff <= best_late_in;
      best_period_ff <= best_period_in;
      pend_slot_ff <= pend_slot_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.scan_last = (scan_idx_ff == SLOT_BITS'(SLOTS - 1));
   assign status.best_valid = best_valid_ff;
   assign status.pend_valid = pend_valid_ff;
   assign status.cap_hit = (fire_cnt_ff == CNT_BITS'(MAX_FIRES - 1));
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_fire_armed: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> best_valid_ff && active_ff[best_idx_ff])
      else $error("fired slot is not armed");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten while waiting");
   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_pend |-> pend_valid_ff)
      else $error("fire emitted with nothing pending");
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= CNT_BITS'(MAX_FIRES))
      else $error("fire count beyond limit");
`endif

endmodule

/* src/multi_slot_timer_scheduler.sv */
// Multi-slot timer scheduler: a table of timer slots served one item at a time.
// Schedule and cancel items give one result each, valid the cycle after
// the item is accepted. A tick item advances the millisecond clock and then scans the
// due-time memory one slot per cycle in rounds; each round fires the most overdue armed
// slot that is due (lower slot on a tie). Rounds go on until no slot is due or sixteen
// timers have fired, and the input is held until the tick is done, also while the result
// side stalls.
// Depends on msts_pkg, msts_ctrl, msts_dp and msts_ram.
module multi_slot_timer_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msts_pkg::rsp_type rsp_data
);
   import msts_pkg::*;

   cmd_type    cmd;
   status_type status;

   msts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   msts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
